// ===== rtl/ecm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_pkg
// Shared types and constants of the edge component merger: request and
// response words, action codes and field widths.
// ----------------------------------------------------------------------------
package ecm_pkg;

   // Field widths of the request, response and control words
   localparam int NODE_W      = 10;
   localparam int LABEL_OUT_W = 10;
   localparam int SIZE_OUT_W  = 11;
   localparam int LIVE_OUT_W  = 10;
   localparam int CFG_W       = 11;

   // Default node capacity and register reset value
   localparam int MAX_NODES_DEF = 1024;
   localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

   // Size of a freshly opened component
   localparam int NEW_SIZE = 2;

   typedef enum logic [1:0] {
      ACT_SKIP  = 2'd0,
      ACT_MERGE = 2'd1,
      ACT_JOIN  = 2'd2,
      ACT_NEW   = 2'd3
   } ecm_action_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } ecm_req_type;

   typedef struct packed {
      ecm_action_type         action;
      logic [LABEL_OUT_W-1:0] component_label;
      logic [SIZE_OUT_W-1:0]  component_size;
      logic [LIVE_OUT_W-1:0]  live_components;
      logic                   all_connected;
   } ecm_rsp_type;

endpackage : ecm_pkg
`default_nettype wire

// ===== rtl/edge_component_merger_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_component_merger_core
// Greedy union of graph nodes into labelled components, one edge per word.
// ----------------------------------------------------------------------------
// Steps: an accepted edge reads both node labels, then reads or updates the
//   label and size memories and returns its word from ST_DONE; an unlabelled
//   self-edge or an index out of range skips the update. A merge of two
//   components also walks the node label memory, one entry per cycle.
// Throughput: one edge at a time, busy until its word has been returned.
// Reset: a clearing pass zeroes both memories with busy high; the node_count
//   register is written at any time. Results cannot stall.
// ----------------------------------------------------------------------------
module edge_component_merger_core #(
   parameter int MAX_NODES = ecm_pkg::MAX_NODES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire ecm_pkg::ecm_req_type      req_data,
   output logic                           rsp_strobe,
   output ecm_pkg::ecm_rsp_type           rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [ecm_pkg::CFG_W-1:0] csr_data
);

   import ecm_pkg::*;

   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int LABEL_SLOTS = MAX_NODES / 2 + 1;
   localparam int LBL_W       = $clog2(LABEL_SLOTS);
   localparam int SIZE_W      = $clog2(MAX_NODES + 1);

   logic [CFG_W-1:0]  node_count_ff;
   logic [IDX_W-1:0]  n_rd_addr;
   logic [LBL_W-1:0]  n_rd_data;
   logic              n_we;
   logic [IDX_W-1:0]  n_wr_addr;
   logic [LBL_W-1:0]  n_wr_data;
   logic [LBL_W-1:0]  s_rd_addr;
   logic [SIZE_W-1:0] s_rd_data;
   logic              s_we;
   logic [LBL_W-1:0]  s_wr_addr;
   logic [SIZE_W-1:0] s_wr_data;

   // Take a node count word whenever offered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   // Node label memory
   ecm_ram #(
      .DEPTH  (MAX_NODES),
      .DATA_W (LBL_W)
   ) u_node_ram (
      .clock   (clock),
      .rd_addr (n_rd_addr),
      .rd_data (n_rd_data),
      .we      (n_we),
      .wr_addr (n_wr_addr),
      .wr_data (n_wr_data)
   );

   // Component size memory, indexed by label
   ecm_ram #(
      .DEPTH  (LABEL_SLOTS),
      .DATA_W (SIZE_W)
   ) u_size_ram (
      .clock   (clock),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data),
      .we      (s_we),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data)
   );

   // Sequencer
   ecm_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .node_count (node_count_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .n_rd_addr  (n_rd_addr),
      .n_rd_data  (n_rd_data),
      .n_we       (n_we),
      .n_wr_addr  (n_wr_addr),
      .n_wr_data  (n_wr_data),
      .s_rd_addr  (s_rd_addr),
      .s_rd_data  (s_rd_data),
      .s_we       (s_we),
      .s_wr_addr  (s_wr_addr),
      .s_wr_data  (s_wr_data)
   );

endmodule : edge_component_merger_core
`default_nettype wire

// ===== rtl/ecm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read (old data on a same-address collision).
// ----------------------------------------------------------------------------
module ecm_ram #(
   parameter int DEPTH  = ecm_pkg::MAX_NODES_DEF,
   parameter int DATA_W = ecm_pkg::LABEL_OUT_W
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Read the old contents, then write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ecm_ram
`default_nettype wire

// ===== rtl/ecm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_ctrl
// Sequencer of the component merger: clears both memories after reset, looks
// up the two node labels, updates labels and sizes by read-modify-write and
// walks the label memory to relabel on a merge.
// ----------------------------------------------------------------------------
module ecm_ctrl #(
   parameter int MAX_NODES = ecm_pkg::MAX_NODES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire ecm_pkg::ecm_req_type                req_data,
   input  wire logic [ecm_pkg::CFG_W-1:0]           node_count,
   output logic                                     rsp_strobe,
   output ecm_pkg::ecm_rsp_type                     rsp_data,
   // node label memory
   output logic [$clog2(MAX_NODES)-1:0]             n_rd_addr,
   input  wire logic [$clog2(MAX_NODES/2+1)-1:0]    n_rd_data,
   output logic                                     n_we,
   output logic [$clog2(MAX_NODES)-1:0]             n_wr_addr,
   output logic [$clog2(MAX_NODES/2+1)-1:0]         n_wr_data,
   // label size memory
   output logic [$clog2(MAX_NODES/2+1)-1:0]         s_rd_addr,
   input  wire logic [$clog2(MAX_NODES+1)-1:0]      s_rd_data,
   output logic                                     s_we,
   output logic [$clog2(MAX_NODES/2+1)-1:0]         s_wr_addr,
   output logic [$clog2(MAX_NODES+1)-1:0]           s_wr_data
);

   import ecm_pkg::*;

   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int LABEL_SLOTS = MAX_NODES / 2 + 1;
   localparam int LBL_W       = $clog2(LABEL_SLOTS);
   localparam int SIZE_W      = $clog2(MAX_NODES + 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_B,
      ST_DECIDE,
      ST_SIZE,
      ST_JOIN,
      ST_NEW_B,
      ST_M_SB,
      ST_M_SUM,
      ST_M_ZERO,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  a_ff;
   logic [IDX_W-1:0]  b_ff;
   logic              same_ff;
   logic [LBL_W-1:0]  la_ff;
   logic [LBL_W-1:0]  lb_ff;
   logic [LBL_W-1:0]  lab_ff;
   logic [SIZE_W-1:0] sa_ff;
   logic [SIZE_W-1:0] size_ff;
   ecm_action_type    act_ff;
   logic [LBL_W-1:0]  next_label_ff;
   logic [LBL_W-1:0]  live_ff;
   logic [SIZE_W-1:0] total_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic              rsp_strobe_ff;
   ecm_rsp_type       rsp_ff;

   logic              accept;
   logic              in_range;
   logic [LBL_W-1:0]  lb_now;
   logic              is_skip;
   logic              is_merge;
   logic              is_join_a;
   logic              is_join_b;
   logic              new_ok;
   logic [LBL_W-1:0]  new_label;
   logic              sweep_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign in_range = (32'(req_data.node_a) < MAX_NODES) &&
                     (32'(req_data.node_b) < MAX_NODES);

   // Classify the edge once both labels are in hand
   assign lb_now    = n_rd_data;
   assign is_skip   = same_ff || ((la_ff != '0) && (la_ff == lb_now));
   assign is_merge  = !is_skip && (la_ff != '0) && (lb_now != '0);
   assign is_join_a = !is_skip && (la_ff != '0) && (lb_now == '0);
   assign is_join_b = !is_skip && (la_ff == '0) && (lb_now != '0);
   assign new_ok    = (32'(next_label_ff) + 1) < LABEL_SLOTS;
   assign new_label = next_label_ff + 1'b1;
   assign sweep_last = (idx_ff == IDX_W'(MAX_NODES - 1));

   // Drive memory ports from the current step
   always_comb begin
      n_rd_addr = '0;
      n_we      = 1'b0;
      n_wr_addr = '0;
      n_wr_data = '0;
      s_rd_addr = '0;
      s_we      = 1'b0;
      s_wr_addr = '0;
      s_wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            n_we      = 1'b1;
            n_wr_addr = idx_ff;
            s_we      = (32'(idx_ff) < LABEL_SLOTS);
            s_wr_addr = LBL_W'(idx_ff);
         end
         ST_IDLE: begin
            n_rd_addr = IDX_W'(req_data.node_a);
         end
         ST_RD_B: begin
            n_rd_addr = b_ff;
         end
         ST_DECIDE: begin
            s_rd_addr = (la_ff != '0) ? la_ff : lb_now;
            if (is_join_a) begin
               n_we      = 1'b1;
               n_wr_addr = b_ff;
               n_wr_data = la_ff;
            end else if (is_join_b) begin
               n_we      = 1'b1;
               n_wr_addr = a_ff;
               n_wr_data = lb_now;
            end else if (!is_skip && !is_merge && new_ok) begin
               n_we      = 1'b1;
               n_wr_addr = a_ff;
               n_wr_data = new_label;
            end
         end
         ST_JOIN: begin
            s_we      = 1'b1;
            s_wr_addr = lab_ff;
            s_wr_data = s_rd_data + 1'b1;
         end
         ST_NEW_B: begin
            n_we      = 1'b1;
            n_wr_addr = b_ff;
            n_wr_data = lab_ff;
            s_we      = 1'b1;
            s_wr_addr = lab_ff;
            s_wr_data = SIZE_W'(NEW_SIZE);
         end
         ST_M_SB: begin
            s_rd_addr = lb_ff;
         end
         ST_M_SUM: begin
            s_we      = 1'b1;
            s_wr_addr = lab_ff;
            s_wr_data = sa_ff + s_rd_data;
         end
         ST_M_ZERO: begin
            s_we      = 1'b1;
            s_wr_addr = lb_ff;
         end
         ST_SWEEP: begin
            n_rd_addr = idx_ff;
            n_we      = pend_ff && (n_rd_data == lb_ff);
            n_wr_addr = pend_idx_ff;
            n_wr_data = lab_ff;
         end
         ST_SWEEP_END: begin
            n_we      = (n_rd_data == lb_ff);
            n_wr_addr = pend_idx_ff;
            n_wr_data = lab_ff;
         end
         default: begin
         end
      endcase
   end

   // Hold state, counters and the registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         next_label_ff <= '0;
         live_ff       <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (sweep_last) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  a_ff    <= IDX_W'(req_data.node_a);
                  b_ff    <= IDX_W'(req_data.node_b);
                  same_ff <= (req_data.node_a == req_data.node_b);
                  if (in_range) begin
                     state_ff <= ST_RD_B;
                  end else begin
                     act_ff   <= ACT_SKIP;
                     lab_ff   <= '0;
                     size_ff  <= '0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_RD_B: begin
               la_ff    <= n_rd_data;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               lb_ff <= lb_now;
               if (is_skip) begin
                  act_ff <= ACT_SKIP;
                  lab_ff <= la_ff;
                  if (la_ff != '0) begin
                     state_ff <= ST_SIZE;
                  end else begin
                     size_ff  <= '0;
                     state_ff <= ST_DONE;
                  end
               end else if (is_merge) begin
                  act_ff   <= ACT_MERGE;
                  lab_ff   <= la_ff;
                  state_ff <= ST_M_SB;
               end else if (is_join_a || is_join_b) begin
                  act_ff   <= ACT_JOIN;
                  lab_ff   <= is_join_a ? la_ff : lb_now;
                  state_ff <= ST_JOIN;
               end else if (new_ok) begin
                  act_ff        <= ACT_NEW;
                  lab_ff        <= new_label;
                  next_label_ff <= new_label;
                  state_ff      <= ST_NEW_B;
               end else begin
                  act_ff   <= ACT_SKIP;
                  lab_ff   <= '0;
                  size_ff  <= '0;
                  state_ff <= ST_DONE;
               end
            end
            ST_SIZE: begin
               size_ff  <= s_rd_data;
               state_ff <= ST_DONE;
            end
            ST_JOIN: begin
               size_ff  <= s_rd_data + 1'b1;
               total_ff <= total_ff + 1'b1;
               state_ff <= ST_DONE;
            end
            ST_NEW_B: begin
               size_ff  <= SIZE_W'(NEW_SIZE);
               live_ff  <= live_ff + 1'b1;
               total_ff <= total_ff + SIZE_W'(NEW_SIZE);
               state_ff <= ST_DONE;
            end
            ST_M_SB: begin
               sa_ff    <= s_rd_data;
               state_ff <= ST_M_SUM;
            end
            ST_M_SUM: begin
               size_ff  <= sa_ff + s_rd_data;
               state_ff <= ST_M_ZERO;
            end
            ST_M_ZERO: begin
               live_ff  <= live_ff - 1'b1;
               idx_ff   <= '0;
               pend_ff  <= 1'b0;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               // read one entry ahead, relabel the one read last cycle
               pend_ff     <= 1'b1;
               pend_idx_ff <= idx_ff;
               if (sweep_last) begin
                  state_ff <= ST_SWEEP_END;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SWEEP_END: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_strobe_ff          <= 1'b1;
               rsp_ff.action          <= act_ff;
               rsp_ff.component_label <= LABEL_OUT_W'(lab_ff);
               rsp_ff.component_size  <= SIZE_OUT_W'(size_ff);
               rsp_ff.live_components <= LIVE_OUT_W'(live_ff);
               rsp_ff.all_connected   <= (live_ff == LBL_W'(1)) &&
                                         (32'(total_ff) == 32'(node_count));
               state_ff               <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every item passes through ST_DONE and back to ST_IDLE, so words never come back to back
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("response strobe on two consecutive cycles");

   // A word only follows the closing step of an item
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_DONE))
      else $error("response strobe without a finished item");

   // No word while the memories are being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_strobe_ff)
      else $error("response during clearing pass");

   // Live components never outnumber labels handed out
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= next_label_ff)
      else $error("live count above issued labels");

   // Labelled nodes never exceed the node capacity
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= MAX_NODES)
      else $error("labelled node count above capacity");

endmodule : ecm_ctrl
`default_nettype wire

// ===== bench/edge_component_merger_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_component_merger_checker
// Watches the edge, response and control channels of the component merger.
// It keeps its own node label and component size tables, works out the
// report that each accepted edge must produce, and compares every response
// word with the oldest outstanding report, field by field.
// ----------------------------------------------------------------------------
module edge_component_merger_checker
   import ecm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire ecm_req_type         req_data,
   input  wire logic                rsp_strobe,
   input  wire ecm_rsp_type         rsp_data,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [CFG_W-1:0]    csr_data,
   output int                       error_count,
   output int                       pending_words,
   output int                       words_checked,
   output int                       merges_seen,
   output int                       spans_seen
);

   localparam int NODE_SLOTS  = MAX_NODES_DEF;
   localparam int LABEL_SLOTS = MAX_NODES_DEF / 2 + 1;

   // Shadow of the block's state
   logic [LABEL_OUT_W-1:0] node_tag [NODE_SLOTS];
   logic [SIZE_OUT_W-1:0]  tag_size [LABEL_SLOTS];
   int                     tags_issued;
   int                     live_total;
   int                     labelled_nodes;
   logic [CFG_W-1:0]       node_count_reg;

   // Reports still owed by the block, oldest first
   ecm_rsp_type            component_reports [$];

   // Clear the shadow tables to the reset state
   task automatic clear_tables();
      int i;
      for (i = 0; i < NODE_SLOTS; i++) node_tag[i] = '0;
      for (i = 0; i < LABEL_SLOTS; i++) tag_size[i] = '0;
      tags_issued    = 0;
      live_total     = 0;
      labelled_nodes = 0;
      node_count_reg = NODE_COUNT_RST;
   endtask

   // Apply one edge to the shadow tables and build the report it causes
   task automatic union_edge(input ecm_req_type link, output ecm_rsp_type report);
      int                     a;
      int                     b;
      int                     i;
      logic [LABEL_OUT_W-1:0] ta;
      logic [LABEL_OUT_W-1:0] tb;
      a = link.node_a;
      b = link.node_b;
      report = '0;
      report.action = ACT_SKIP;
      if (a < NODE_SLOTS && b < NODE_SLOTS) begin
         ta = node_tag[a];
         tb = node_tag[b];
         if (a == b || (ta != 0 && ta == tb)) begin
            report.action = ACT_SKIP;
         end else if (ta != 0 && tb != 0) begin
            // relabel the whole of b's component into a's
            for (i = 0; i < NODE_SLOTS; i++)
               if (node_tag[i] == tb) node_tag[i] = ta;
            tag_size[ta] = tag_size[ta] + tag_size[tb];
            tag_size[tb] = '0;
            live_total--;
            report.action = ACT_MERGE;
         end else if (ta != 0) begin
            node_tag[b] = ta;
            tag_size[ta] = tag_size[ta] + 1'b1;
            labelled_nodes++;
            report.action = ACT_JOIN;
         end else if (tb != 0) begin
            node_tag[a] = tb;
            tag_size[tb] = tag_size[tb] + 1'b1;
            labelled_nodes++;
            report.action = ACT_JOIN;
         end else if (tags_issued + 1 < LABEL_SLOTS) begin
            // open a fresh component of two nodes
            tags_issued++;
            node_tag[a] = tags_issued[LABEL_OUT_W-1:0];
            node_tag[b] = tags_issued[LABEL_OUT_W-1:0];
            tag_size[tags_issued] = NEW_SIZE[SIZE_OUT_W-1:0];
            labelled_nodes += NEW_SIZE;
            live_total++;
            report.action = ACT_NEW;
         end
         report.component_label = node_tag[a];
         report.component_size  = (node_tag[a] != 0) ? tag_size[node_tag[a]] : '0;
      end
      report.live_components = live_total[LIVE_OUT_W-1:0];
      report.all_connected   = (live_total == 1 && labelled_nodes == node_count_reg);
   endtask

   // Track control writes, check responses, predict accepted edges
   always @(posedge clock) begin : watch
      ecm_rsp_type report;
      ecm_rsp_type owed;
      if (reset) begin
         clear_tables();
         component_reports.delete();
         error_count   = 0;
         words_checked = 0;
         merges_seen   = 0;
         spans_seen    = 0;
      end else begin
         if (csr_valid && csr_ready) node_count_reg = csr_data;

         if (rsp_strobe) begin
            if (component_reports.size() == 0) begin
               $error("response word with no edge outstanding");
               error_count++;
            end else begin
               owed = component_reports.pop_front();
               words_checked++;
               if (rsp_data.action == ACT_MERGE) merges_seen++;
               if (rsp_data.all_connected) spans_seen++;
               if (rsp_data.action !== owed.action) begin
                  $error("action: expected %0d, got %0d", owed.action, rsp_data.action);
                  error_count++;
               end
               if (rsp_data.component_label !== owed.component_label) begin
                  $error("component_label: expected %0d, got %0d",
                         owed.component_label, rsp_data.component_label);
                  error_count++;
               end
               if (rsp_data.component_size !== owed.component_size) begin
                  $error("component_size: expected %0d, got %0d",
                         owed.component_size, rsp_data.component_size);
                  error_count++;
               end
               if (rsp_data.live_components !== owed.live_components) begin
                  $error("live_components: expected %0d, got %0d",
                         owed.live_components, rsp_data.live_components);
                  error_count++;
               end
               if (rsp_data.all_connected !== owed.all_connected) begin
                  $error("all_connected: expected %0d, got %0d",
                         owed.all_connected, rsp_data.all_connected);
                  error_count++;
               end
            end
         end

         if (start && !busy) begin
            union_edge(req_data, report);
            component_reports.push_back(report);
         end
      end
      pending_words = component_reports.size();
   end

endmodule : edge_component_merger_checker

// ===== bench/edge_component_merger_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_component_merger_core_tb
// Drives edges into the component merger: a directed opening over every
// action, then random edge sets over growing node pools, some closed into
// one component by a sweep, with node_count set to reach, miss and exceed
// the spanning size. The checker beside the block predicts every word.
// ----------------------------------------------------------------------------
module edge_component_merger_core_tb;
   import ecm_pkg::*;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ecm_req_type       req_data;
   logic              rsp_strobe;
   ecm_rsp_type       rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_data;

   int                error_count;
   int                pending_words;
   int                words_checked;
   int                merges_seen;
   int                spans_seen;

   int                items_sent;
   int                idle_pct;
   int                pool_nodes [$];

   edge_component_merger_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   edge_component_merger_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .merges_seen   (merges_seen),
      .spans_seen    (spans_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

   // Offer one edge word; return on the falling edge after it is taken
   task automatic send_link(input int a, input int b);
      ecm_req_type word;
      word.node_a = a[NODE_W-1:0];
      word.node_b = b[NODE_W-1:0];
      req_data <= word;
      start    <= 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      items_sent++;
      // drop start for a random burst now and then
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // Drain outstanding words, then write the node count register
   task automatic write_node_count(input int value);
      start <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_data  <= value[CFG_W-1:0];
      csr_valid <= 1'b1;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Build the pool: nodes below span plus the high nodes from the opening
   task automatic fill_pool(input int span);
      int i;
      pool_nodes.delete();
      for (i = 0; i < span; i++) pool_nodes.push_back(i);
      pool_nodes.push_back(341);
      pool_nodes.push_back(512);
      pool_nodes.push_back(682);
      pool_nodes.push_back(1023);
   endtask

   // Random edges inside the pool, then an optional sweep chaining it whole
   task automatic run_pool_phase(input int span, input int count, input bit sweep);
      int i;
      int n;
      fill_pool(span);
      n = pool_nodes.size();
      for (i = 0; i < count; i++)
         send_link(pool_nodes[$urandom_range(0, n - 1)], pool_nodes[$urandom_range(0, n - 1)]);
      if (sweep) begin
         for (i = 0; i + 1 < n; i++) begin
            if ($urandom_range(0, 99) < 20)
               send_link(pool_nodes[$urandom_range(0, n - 1)],
                         pool_nodes[$urandom_range(0, n - 1)]);
            if ($urandom_range(0, 1))
               send_link(pool_nodes[i], pool_nodes[i + 1]);
            else
               send_link(pool_nodes[i + 1], pool_nodes[i]);
         end
      end
   endtask

   initial begin : stimulus
      int i;
      int a;
      int pick;
      int drain_cycles;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      items_sent = 0;
      idle_pct   = 30;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening: every action, self edges, both join sides, both merge orders
      write_node_count(2);
      send_link(0, 0);
      send_link(0, 1);
      send_link(1, 0);
      send_link(1, 1);
      send_link(1023, 512);
      send_link(2, 1023);
      send_link(1023, 3);
      send_link(0, 512);
      send_link(682, 341);
      send_link(341, 1023);
      send_link(4, 5);
      send_link(6, 7);
      send_link(5, 6);
      send_link(7, 4);
      send_link(1023, 1023);

      // Growing pools, each closed into one spanning component
      idle_pct = 0;
      write_node_count(20);
      run_pool_phase(16, 10, 1'b1);
      idle_pct = 40;
      write_node_count(68);
      run_pool_phase(64, 35, 1'b1);

      // Node counts that no component can match, then one a closing sweep reaches
      idle_pct = 25;
      write_node_count(2047);
      run_pool_phase(200, 20, 1'b0);
      write_node_count(0);
      run_pool_phase(200, 20, 1'b0);
      idle_pct = 50;
      write_node_count(204);
      run_pool_phase(200, 20, 1'b1);

      // Full index range; no idling in the closing half
      write_node_count(1024);
      for (i = 0; i < 120; i++) begin
         if (i == 60) idle_pct = 0;
         pick = $urandom_range(0, 99);
         a = $urandom_range(0, 1023);
         if (pick < 10)
            send_link(a, a);
         else if (pick < 20)
            send_link($urandom_range(0, 1) ? 1023 : 0, $urandom_range(0, 1) ? 1023 : 0);
         else
            send_link(a, $urandom_range(0, 1023));
      end

      // Wind down: wait for every word, then past the longest merge
      start <= 1'b0;
      drain_cycles = 0;
      while (pending_words != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (MAX_NODES_DEF + 16) @(negedge clock);

      $display("Sent %0d edges across node counts 0, 2, 20, 68, 204, 1024 and 2047.",
               items_sent);
      $display("Checked %0d words: %0d merges, %0d spanning reports, %0d mismatches.",
               words_checked, merges_seen, spans_seen, error_count);
      if (error_count == 0 && pending_words == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule : edge_component_merger_core_tb
